FILE: hdl/scfb_pkg.sv
// Shared types, constants and helpers of the scaled framebuffer blitter.
package scfb_pkg;

  localparam int MAX_SIDE_DEF  = 4096;
  localparam int MAX_SCALE_DEF = 8;
  localparam int QUEUE_DEPTH   = 4;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_LINE_PITCH     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_BITS_PER_PIXEL = 3'd3;
  localparam logic [CFG_IW-1:0] REG_BLIT_X         = 3'd4;
  localparam logic [CFG_IW-1:0] REG_BLIT_Y         = 3'd5;
  localparam logic [CFG_IW-1:0] REG_BLIT_WIDTH     = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SCALE          = 3'd7;

  localparam logic [7:0]  BPP_24       = 8'd24;
  localparam logic [7:0]  BPP_32       = 8'd32;
  localparam logic [31:0] COLOR24_MASK = 32'h00FF_FFFF;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [15:0] line_pitch;
    logic [7:0]  bits_per_pixel;
    logic [11:0] blit_x;
    logic [11:0] blit_y;
    logic [12:0] blit_width;
    logic [3:0]  scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    screen_width:   13'd0,
    screen_height:  13'd0,
    line_pitch:     16'd0,
    bits_per_pixel: BPP_32,
    blit_x:         12'd0,
    blit_y:         12'd0,
    blit_width:     13'd1,
    scale:          4'd1
  };

  function automatic logic [3:0] eff_scale(input logic [3:0] s, input logic [3:0] smax);
    logic [3:0] r;
    if (s == 4'd0) begin
      r = 4'd1;
    end else if (s > smax) begin
      r = smax;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic bad_depth(input logic [7:0] bpp);
    return (bpp != BPP_24) && (bpp != BPP_32);
  endfunction

endpackage

FILE: hdl/scfb_fifo.sv
// Small register queue between the front and back parts.
module scfb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = scfb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: hdl/scfb_front.sv
// Front part: tracks the source position, decides errors, computes the base offset.
module scfb_front #(
  parameter int MAX_SIDE  = scfb_pkg::MAX_SIDE_DEF,
  parameter int MAX_SCALE = scfb_pkg::MAX_SCALE_DEF,
  parameter int XW        = 20,
  parameter int EW        = 33 + 2*XW + 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scfb_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_color,
  input  logic                in_last,
  output logic                q_wr,
  input  logic                q_full,
  output logic [EW-1:0]       q_data
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int BW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam int MW = (XW + 16 > 32) ? XW + 16 : 32;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic          aborted_r, aborted_nxt;

  logic          s2_valid_r, s2_valid_nxt;
  logic [31:0]   s2_color_r;
  logic          s2_last_r;
  logic [XW-1:0] s2_x0_r, s2_y0_r;

  logic [3:0]    s_eff;
  logic [SW-1:0] s;
  logic [XW-1:0] x0, y0;
  logic          err;
  logic [CW:0]   col_inc;
  logic          accept;
  logic [MW-1:0] y_term, x_term;
  logic [4:0]    bpb;

  assign s_eff = scfb_pkg::eff_scale(cfg.scale, 4'(MAX_SCALE));
  assign s     = s_eff[SW-1:0];
  assign x0    = XW'(cfg.blit_x) + XW'(col_r) * XW'(s);
  assign y0    = XW'(cfg.blit_y) + XW'(row_r) * XW'(s);
  assign err   = scfb_pkg::bad_depth(cfg.bits_per_pixel)
               || (x0 + XW'(s) > XW'(cfg.screen_width))
               || (y0 + XW'(s) > XW'(cfg.screen_height));

  assign in_ready = !s2_valid_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign col_inc  = {1'b0, col_r} + (CW+1)'(1);

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    aborted_nxt  = aborted_r;
    s2_valid_nxt = s2_valid_r && q_full;
    if (accept) begin
      if (aborted_r) begin
        if (in_last) begin
          aborted_nxt = 1'b0;
          col_nxt     = '0;
          row_nxt     = '0;
        end
      end else begin
        s2_valid_nxt = 1'b1;
        if (in_last) begin
          col_nxt = '0;
          row_nxt = '0;
        end else if (err) begin
          aborted_nxt = 1'b1;
        end else if ((col_inc >= (CW+1)'(MAX_SIDE))
                     || (BW'(col_inc) >= BW'(cfg.blit_width))) begin
          col_nxt = '0;
          row_nxt = (row_r == CW'(MAX_SIDE - 1)) ? '0 : row_r + CW'(1);
        end else begin
          col_nxt = col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      aborted_r  <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      aborted_r  <= aborted_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !aborted_r) begin
      s2_color_r <= in_color;
      s2_last_r  <= in_last;
      s2_x0_r    <= x0;
      s2_y0_r    <= y0;
    end
  end

  assign bpb    = cfg.bits_per_pixel[7:3];
  assign y_term = MW'(s2_y0_r) * MW'(cfg.line_pitch);
  assign x_term = MW'(s2_x0_r) * MW'(bpb);

  assign q_wr   = s2_valid_r && !q_full;
  assign q_data = {s2_color_r, s2_last_r, s2_x0_r, s2_y0_r, y_term[31:0] + x_term[31:0]};

endmodule

FILE: hdl/scfb_back.sv
// Back part: walks the scale square of each queued pixel and issues the writes.
module scfb_back #(
  parameter int MAX_SCALE = scfb_pkg::MAX_SCALE_DEF,
  parameter int XW        = 20,
  parameter int EW        = 33 + 2*XW + 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  scfb_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  logic [EW-1:0]   q_data,
  output logic            q_rd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_offset,
  output logic [31:0]     out_data,
  output logic            out_wide,
  output logic            out_status,
  output logic            out_run_last,
  output logic            out_done
);

  localparam int SW = $clog2(MAX_SCALE + 1);

  logic [31:0]   h_base;
  logic [XW-1:0] h_y0, h_x0;
  logic          h_last;
  logic [31:0]   h_color;

  logic          active_r;
  logic [SW-1:0] sx_r, sy_r;
  logic [XW-1:0] x_r, y_r, x0_r;
  logic [31:0]   off_r, row_off_r, color_r;
  logic          last_r;

  logic [SW-1:0] c_sx, c_sy;
  logic [XW-1:0] c_x, c_y, c_x0;
  logic [31:0]   c_off, c_row_off, c_color;
  logic          c_last;

  logic          ov_r;
  logic [31:0]   o_off_r, o_data_r;
  logic          o_wide_r, o_status_r, o_rlast_r, o_done_r;

  logic [3:0]    s_eff;
  logic [SW-1:0] s_m1;
  logic          step, fail, final_one, row_end, item_end;
  logic [31:0]   next_row_off;
  logic          is32;

  assign h_base  = q_data[31:0];
  assign h_y0    = q_data[32 +: XW];
  assign h_x0    = q_data[32+XW +: XW];
  assign h_last  = q_data[32+2*XW];
  assign h_color = q_data[33+2*XW +: 32];

  assign c_sx      = active_r ? sx_r      : '0;
  assign c_sy      = active_r ? sy_r      : '0;
  assign c_x       = active_r ? x_r       : h_x0;
  assign c_y       = active_r ? y_r       : h_y0;
  assign c_x0      = active_r ? x0_r      : h_x0;
  assign c_off     = active_r ? off_r     : h_base;
  assign c_row_off = active_r ? row_off_r : h_base;
  assign c_color   = active_r ? color_r   : h_color;
  assign c_last    = active_r ? last_r    : h_last;

  assign s_eff     = scfb_pkg::eff_scale(cfg.scale, 4'(MAX_SCALE));
  assign s_m1      = s_eff[SW-1:0] - SW'(1);
  assign is32      = (cfg.bits_per_pixel == scfb_pkg::BPP_32);
  assign step      = (active_r || !q_empty) && (!ov_r || out_ready);
  assign fail      = (c_x >= XW'(cfg.screen_width)) || (c_y >= XW'(cfg.screen_height))
                   || scfb_pkg::bad_depth(cfg.bits_per_pixel);
  assign row_end   = (c_sx == s_m1);
  assign final_one = row_end && (c_sy == s_m1);
  assign item_end  = fail || final_one;
  assign q_rd      = step && !active_r;
  assign next_row_off = c_row_off + {16'd0, cfg.line_pitch};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (step) begin
        active_r <= !item_end;
        ov_r     <= 1'b1;
      end else if (out_ready) begin
        ov_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !item_end) begin
      x0_r    <= c_x0;
      color_r <= c_color;
      last_r  <= c_last;
      if (row_end) begin
        sx_r      <= '0;
        sy_r      <= c_sy + SW'(1);
        x_r       <= c_x0;
        y_r       <= c_y + XW'(1);
        row_off_r <= next_row_off;
        off_r     <= next_row_off;
      end else begin
        sx_r      <= c_sx + SW'(1);
        sy_r      <= c_sy;
        x_r       <= c_x + XW'(1);
        y_r       <= c_y;
        row_off_r <= c_row_off;
        off_r     <= c_off + {27'd0, cfg.bits_per_pixel[7:3]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (fail) begin
        o_off_r    <= '0;
        o_data_r   <= '0;
        o_wide_r   <= 1'b0;
        o_status_r <= 1'b1;
        o_rlast_r  <= 1'b1;
        o_done_r   <= 1'b1;
      end else begin
        o_off_r    <= c_off;
        o_data_r   <= is32 ? c_color : (c_color & scfb_pkg::COLOR24_MASK);
        o_wide_r   <= is32;
        o_status_r <= 1'b0;
        o_rlast_r  <= final_one;
        o_done_r   <= final_one && c_last;
      end
    end
  end

  assign out_valid    = ov_r;
  assign out_offset   = o_off_r;
  assign out_data     = o_data_r;
  assign out_wide     = o_wide_r;
  assign out_status   = o_status_r;
  assign out_run_last = o_rlast_r;
  assign out_done     = o_done_r;

endmodule

FILE: hdl/scaled_framebuffer_blitter.sv
// Top level of the scaled framebuffer blitter: config registers, front, queue, back.
//
// Usage: source pixels enter on the in_ stream in row-major order, in_tlast on the
// final pixel of a bitmap. Each pixel leaves as scale*scale framebuffer writes on
// the out_ stream (byte offset relative to the framebuffer base and the colour),
// square rows first. A target off screen or a depth other than 24/32 gives a single
// error transfer and aborts the blit; following pixels are swallowed until the one
// carrying in_tlast, which rearms the block.
// Configuration is written through cfg_we/cfg_index/cfg_data by the user only while no blit runs;
// the block itself does not enforce this.
// Throughput: one write per cycle while out_tready is high and pixels are queued, the back-end
// square walker issuing scale*scale writes per pixel; an erroring pixel ends with its error
// transfer, which follows the writes that precede it, and swallowed pixels are dropped in the front.
// A 4-entry queue separates the front and back.
// Reset (synchronous, rst_n low) restores the register defaults, clears the source
// position and the abort flag and empties the queue and the output register.
// When the receiver stalls, the output holds and the queue fills; in_tready then
// drops until space frees up.
module scaled_framebuffer_blitter #(
  parameter int MAX_SIDE  = scfb_pkg::MAX_SIDE_DEF,
  parameter int MAX_SCALE = scfb_pkg::MAX_SCALE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // pixel_color
  input  logic                        in_tlast,   // last_pixel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [63:0]                 out_tdata,  // byte_offset, pixel_data
  output logic [2:0]                  out_tuser,  // wide_write, status, blit_done
  output logic                        out_tlast,  // run_last
  input  logic                        cfg_we,
  input  logic [scfb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [scfb_pkg::CFG_DW-1:0] cfg_data
);

  localparam int XW = $clog2(4096 + MAX_SIDE * MAX_SCALE) + 1;
  localparam int EW = 33 + 2*XW + 32;

  scfb_pkg::cfg_t cfg_r;

  logic          q_wr, q_full, q_rd, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;
  logic [31:0]   o_offset, o_data;
  logic          o_wide, o_status, o_rlast, o_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= scfb_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scfb_pkg::REG_SCREEN_WIDTH:   cfg_r.screen_width   <= cfg_data[12:0];
        scfb_pkg::REG_SCREEN_HEIGHT:  cfg_r.screen_height  <= cfg_data[12:0];
        scfb_pkg::REG_LINE_PITCH:     cfg_r.line_pitch     <= cfg_data[15:0];
        scfb_pkg::REG_BITS_PER_PIXEL: cfg_r.bits_per_pixel <= cfg_data[7:0];
        scfb_pkg::REG_BLIT_X:         cfg_r.blit_x         <= cfg_data[11:0];
        scfb_pkg::REG_BLIT_Y:         cfg_r.blit_y         <= cfg_data[11:0];
        scfb_pkg::REG_BLIT_WIDTH:     cfg_r.blit_width     <= cfg_data[12:0];
        scfb_pkg::REG_SCALE:          cfg_r.scale          <= cfg_data[3:0];
        default:                      cfg_r                <= cfg_r;
      endcase
    end
  end

  scfb_front #(
    .MAX_SIDE  (MAX_SIDE),
    .MAX_SCALE (MAX_SCALE),
    .XW        (XW),
    .EW        (EW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_color (in_tdata),
    .in_last  (in_tlast),
    .q_wr     (q_wr),
    .q_full   (q_full),
    .q_data   (q_wdata)
  );

  scfb_fifo #(
    .WIDTH (EW),
    .DEPTH (scfb_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  scfb_back #(
    .MAX_SCALE (MAX_SCALE),
    .XW        (XW),
    .EW        (EW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_rd         (q_rd),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_offset   (o_offset),
    .out_data     (o_data),
    .out_wide     (o_wide),
    .out_status   (o_status),
    .out_run_last (o_rlast),
    .out_done     (o_done)
  );

  assign out_tdata = {o_data, o_offset};
  assign out_tuser = {o_done, o_status, o_wide};
  assign out_tlast = o_rlast;

endmodule
